### rtl/core/sm3_pkg.sv
// Package for the SM3 hash core: constants, state type and round helpers.
// Depends on nothing; used by sm3_hash_core.
package sm3_pkg;

    localparam logic [31:0] T_LOW  = 32'h79cc4519;
    localparam logic [31:0] T_HIGH = 32'h7a879d8a;
    localparam logic [31:0] PAD_WORD = 32'h80000000;

    localparam logic [255:0] SM3_IV = {
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD,
        ST_OUT
    } sm3_state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

### rtl/core/sm3_hash_core.sv
// SM3 hash core: block buffer, padding sequencer and one shared round unit.
// Depends on sm3_pkg.
// A word that does not fill a block is just stored. A word that fills a block
// starts the rounds, one round per cycle through the single round unit with
// its 16-word expansion window. A final word starts padding: pad words, zeros
// and the 64-bit length are pushed and compressed, then eight digest transfers.
// Reset: chaining value returns to the IV, fill count and length to zero.
module sm3_hash_core
    import sm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] msg_word,
    input  logic [2:0]  byte_count,
    input  logic        end_of_message,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        digest_last
);

    sm3_state_t   state_reg, state_next;
    logic [31:0]  buf_reg [16];
    logic [31:0]  win_reg [16];
    logic [31:0]  v_reg [8];
    logic [31:0]  r_reg [8];
    logic [3:0]   fill_reg, fill_next;
    logic [63:0]  len_reg, len_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic         padding_reg, padding_next;
    logic         pad_seen_reg, pad_seen_next;
    logic [2:0]   oidx_reg, oidx_next;
    logic         len_written_reg, len_written_next;

    logic         push;
    logic [31:0]  push_word;
    logic         start_round;
    logic         round_en;
    logic         in_fire;
    logic [2:0]   cnt;
    logic [31:0]  keep;
    logic [31:0]  pw;

    logic [31:0] a12, ss1, ss2, ffv, ggv, tt1, tt2, tj, wnew;

    assign in_fire = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign digest_word = v_reg[oidx_reg];
    assign digest_index = oidx_reg;
    assign digest_last = (oidx_reg == 3'd7);

    always_comb
    begin
        cnt = (byte_count > 3'd4) ? 3'd4 : byte_count;
        keep = (cnt == 3'd0) ? 32'h0 : (32'hffffffff << (6'd32 - {cnt, 3'b000}));
        pw = (msg_word & keep) | (PAD_WORD >> {cnt, 3'b000});
    end

    always_comb
    begin
        tj = (rnd_reg < 6'd16) ? T_LOW : T_HIGH;
        a12 = rotl(r_reg[0], 5'd12);
        ss1 = rotl(a12 + r_reg[4] + rotl(tj, rnd_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (rnd_reg < 6'd16)
        begin
            ffv = r_reg[0] ^ r_reg[1] ^ r_reg[2];
            ggv = r_reg[4] ^ r_reg[5] ^ r_reg[6];
        end
        else
        begin
            ffv = (r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]);
            ggv = (r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]);
        end
        tt1 = ffv + r_reg[3] + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = ggv + r_reg[7] + ss1 + win_reg[0];
        wnew = p1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 5'd15))
             ^ rotl(win_reg[3], 5'd7) ^ win_reg[10];
    end

    always_comb
    begin
        state_next = state_reg;
        fill_next = fill_reg;
        len_next = len_reg;
        rnd_next = rnd_reg;
        padding_next = padding_reg;
        pad_seen_next = pad_seen_reg;
        oidx_next = oidx_reg;
        push = 1'b0;
        push_word = 32'h0;
        round_en = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    push = 1'b1;
                    if (!end_of_message)
                    begin
                        push_word = msg_word;
                        len_next = len_reg + 64'd32;
                    end
                    else
                    begin
                        len_next = len_reg + {58'd0, cnt, 3'b000};
                        padding_next = 1'b1;
                        pad_seen_next = (cnt != 3'd4);
                        push_word = (cnt == 3'd4) ? msg_word : pw;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                push = 1'b1;
                if (!pad_seen_reg)
                begin
                    push_word = PAD_WORD;
                    pad_seen_next = 1'b1;
                end
                else if (fill_reg == 4'd14)
                    push_word = len_reg[63:32];
                else if (fill_reg == 4'd15 && len_written_reg)
                    push_word = len_reg[31:0];
                else
                    push_word = 32'h0;
            end
            ST_ROUND:
            begin
                round_en = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    if (!padding_reg)
                        state_next = ST_IDLE;
                    else if (fill_reg == 4'd0 && pad_seen_reg && len_written_reg)
                    begin
                        state_next = ST_OUT;
                        oidx_next = 3'd0;
                    end
                    else
                        state_next = ST_PAD;
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        padding_next = 1'b0;
                        len_next = 64'd0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (push)
        begin
            fill_next = fill_reg + 4'd1;
            if (fill_reg == 4'd15)
            begin
                state_next = ST_ROUND;
                rnd_next = 6'd0;
            end
        end
    end

    always_comb
    begin
        len_written_next = len_written_reg;
        if (state_reg == ST_PAD && pad_seen_reg && fill_reg == 4'd14)
            len_written_next = 1'b1;
        if (state_reg == ST_OUT)
            len_written_next = 1'b0;
    end

    assign start_round = push && (fill_reg == 4'd15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg <= 4'd0;
            len_reg <= 64'd0;
            rnd_reg <= 6'd0;
            padding_reg <= 1'b0;
            pad_seen_reg <= 1'b0;
            oidx_reg <= 3'd0;
            len_written_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
                v_reg[i] <= SM3_IV[255 - 32*i -: 32];
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            len_reg <= len_next;
            rnd_reg <= rnd_next;
            padding_reg <= padding_next;
            pad_seen_reg <= pad_seen_next;
            oidx_reg <= oidx_next;
            len_written_reg <= len_written_next;
            if (round_en && rnd_reg == 6'd63)
            begin
                v_reg[0] <= v_reg[0] ^ tt1;
                v_reg[1] <= v_reg[1] ^ r_reg[0];
                v_reg[2] <= v_reg[2] ^ rotl(r_reg[1], 5'd9);
                v_reg[3] <= v_reg[3] ^ r_reg[2];
                v_reg[4] <= v_reg[4] ^ p0(tt2);
                v_reg[5] <= v_reg[5] ^ r_reg[4];
                v_reg[6] <= v_reg[6] ^ rotl(r_reg[5], 5'd19);
                v_reg[7] <= v_reg[7] ^ r_reg[6];
            end
            if (state_reg == ST_OUT && !out_stall && oidx_reg == 3'd7)
            begin
                for (int i = 0; i < 8; i++)
                    v_reg[i] <= SM3_IV[255 - 32*i -: 32];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[fill_reg] <= push_word;
        if (start_round)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= buf_reg[i];
            win_reg[15] <= push_word;
            for (int i = 0; i < 8; i++)
                r_reg[i] <= v_reg[i];
        end
        else if (round_en)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= wnew;
            r_reg[0] <= tt1;
            r_reg[1] <= r_reg[0];
            r_reg[2] <= rotl(r_reg[1], 5'd9);
            r_reg[3] <= r_reg[2];
            r_reg[4] <= p0(tt2);
            r_reg[5] <= r_reg[4];
            r_reg[6] <= rotl(r_reg[5], 5'd19);
            r_reg[7] <= r_reg[6];
        end
    end

endmodule

### tb/sm3_hash_core_tb.sv
// Testbench for sm3_hash_core: feeds directed and random message word streams
// and checks every digest transfer against an SM3 predictor in the testbench.
// Depends on sm3_pkg and sm3_hash_core.
`timescale 1ns / 100ps

module sm3_hash_core_tb;
    import sm3_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  count;
        logic        eom;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_item_t;

    localparam int HOLD_OFF_CYCLES = 600;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] msg_word;
    logic [2:0]  byte_count;
    logic        end_of_message;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;

    msg_item_t    pending_words[$];
    digest_item_t expected_digests[$];

    logic [31:0] chain[8];
    logic [31:0] block_words[16];
    int          fill_count;
    logic [63:0] bit_length;

    int  errors;
    int  cycle_count;
    int  burst_left;
    int  gap_left;
    int  hold_off_left;
    bit  generation_done;

    sm3_hash_core u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .msg_word(msg_word),
        .byte_count(byte_count),
        .end_of_message(end_of_message),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .digest_word(digest_word),
        .digest_index(digest_index),
        .digest_last(digest_last)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic logic [31:0] rot_left(logic [31:0] x, int n);
        int s;
        s = n % 32;
        if (s == 0)
            return x;
        return (x << s) | (x >> (32 - s));
    endfunction

    task automatic compress_chain();
        logic [31:0] w[68];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] tj, a12, ss1, ss2, ffv, ggv, tt1, tt2;
        for (int j = 0; j < 16; j++)
            w[j] = block_words[j];
        for (int j = 16; j < 68; j++)
        begin
            tt1 = w[j-16] ^ w[j-9] ^ rot_left(w[j-3], 15);
            w[j] = tt1 ^ rot_left(tt1, 15) ^ rot_left(tt1, 23)
                 ^ rot_left(w[j-13], 7) ^ w[j-6];
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int j = 0; j < 64; j++)
        begin
            tj = (j < 16) ? T_LOW : T_HIGH;
            a12 = rot_left(a, 12);
            ss1 = rot_left(a12 + e + rot_left(tj, j), 7);
            ss2 = ss1 ^ a12;
            if (j < 16)
            begin
                ffv = a ^ b ^ c;
                ggv = e ^ f ^ g;
            end
            else
            begin
                ffv = (a & b) | (a & c) | (b & c);
                ggv = (e & f) | (~e & g);
            end
            tt1 = ffv + d + ss2 + (w[j] ^ w[j+4]);
            tt2 = ggv + h + ss1 + w[j];
            d = c; c = rot_left(b, 9); b = a; a = tt1;
            h = g; g = rot_left(f, 19); f = e;
            e = tt2 ^ rot_left(tt2, 9) ^ rot_left(tt2, 17);
        end
        chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
        chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
    endtask

    task automatic append_word(logic [31:0] word);
        block_words[fill_count] = word;
        fill_count = (fill_count + 1) % 16;
        if (fill_count == 0)
            compress_chain();
    endtask

    task automatic reset_chain();
        for (int k = 0; k < 8; k++)
            chain[k] = SM3_IV[255 - 32*k -: 32];
        fill_count = 0;
        bit_length = '0;
    endtask

    task automatic predict_digest(msg_item_t item);
        int n;
        logic [31:0] keep;
        digest_item_t r;
        if (!item.eom)
        begin
            bit_length += 64'd32;
            append_word(item.word);
            return;
        end
        n = (item.count > 3'd4) ? 4 : int'(item.count);
        bit_length += 64'(8 * n);
        if (n == 4)
        begin
            append_word(item.word);
            append_word(PAD_WORD);
        end
        else
        begin
            keep = (n == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * n));
            append_word((item.word & keep) | (PAD_WORD >> (8 * n)));
        end
        while (fill_count != 14)
            append_word(32'h0);
        append_word(bit_length[63:32]);
        append_word(bit_length[31:0]);
        for (int k = 0; k < 8; k++)
        begin
            r.word = chain[k];
            r.index = 3'(k);
            r.last = (k == 7);
            expected_digests.push_back(r);
        end
        reset_chain();
    endtask

    task automatic queue_message(int words, logic [2:0] tail_count);
        msg_item_t item;
        for (int i = 0; i < words; i++)
        begin
            item.word = $urandom;
            item.eom = (i == words - 1);
            item.count = item.eom ? tail_count : 3'($urandom_range(0, 7));
            pending_words.push_back(item);
        end
    endtask

    task automatic queue_fixed(logic [31:0] word, logic [2:0] count, logic eom);
        msg_item_t item;
        item.word = word;
        item.count = count;
        item.eom = eom;
        pending_words.push_back(item);
    endtask

    initial
    begin
        int total;
        int len;
        errors = 0;
        generation_done = 1'b0;
        queue_fixed(32'h0, 3'd0, 1'b1);
        queue_fixed(32'h61626300, 3'd3, 1'b1);
        queue_fixed(32'hffffffff, 3'd4, 1'b1);
        queue_fixed(32'hffffffff, 3'd7, 1'b1);
        queue_fixed(32'h12345678, 3'd5, 1'b1);
        queue_fixed(32'hffffffff, 3'd1, 1'b0);
        queue_fixed(32'h00000000, 3'd2, 1'b1);
        queue_fixed(32'hffffffff, 3'd6, 1'b1);
        for (int i = 0; i < 13; i++)
            queue_fixed(32'h5a5a5a5a + i, 3'd4, 1'b0);
        queue_fixed(32'hdeadbeef, 3'd4, 1'b1);
        total = pending_words.size();
        while (total < 210)
        begin
            case ($urandom_range(0, 3))
                0: len = $urandom_range(1, 3);
                1: len = $urandom_range(13, 17);
                2: len = $urandom_range(28, 34);
                default: len = $urandom_range(1, 12);
            endcase
            queue_message(len, 3'($urandom_range(0, 7)));
            total += len;
        end
        generation_done = 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Sender: bursts and gaps; after the directed words it waits for the
    // digests to drain once. The receiver's long hold-off is armed once over 40 words are sent.
    int sent_words;
    bit drain_pause;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            msg_word <= '0;
            byte_count <= '0;
            end_of_message <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
            sent_words = 0;
            drain_pause = 1'b0;
            reset_chain();
        end
        else
        begin
            if (in_valid && !in_stall)
                sent_words++;
            if (!in_valid || !in_stall)
            begin
                if (sent_words == 22 && !drain_pause)
                begin
                    drain_pause = (expected_digests.size() == 0);
                    in_valid <= 1'b0;
                end
                else if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    msg_item_t item;
                    item = pending_words.pop_front();
                    predict_digest(item);
                    msg_word <= item.word;
                    byte_count <= item.count;
                    end_of_message <= item.eom;
                    in_valid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 30);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off early in the random part.
    int stall_phase;
    bit hold_done;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_phase = 0;
            hold_off_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            stall_phase++;
            if (!hold_done && sent_words > 40)
            begin
                hold_done = 1'b1;
                hold_off_left = HOLD_OFF_CYCLES;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                out_stall <= 1'b1;
            end
            else if ((stall_phase / 64) % 3 == 0)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 40);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_digests.size() == 0)
            begin
                $display("%0t: unexpected digest transfer word=%h index=%0d last=%0b",
                         $time, digest_word, digest_index, digest_last);
                errors++;
            end
            else
            begin
                digest_item_t exp_d;
                exp_d = expected_digests.pop_front();
                if (digest_word !== exp_d.word)
                begin
                    $display("%0t: digest_word expected %h actual %h",
                             $time, exp_d.word, digest_word);
                    errors++;
                end
                if (digest_index !== exp_d.index)
                begin
                    $display("%0t: digest_index expected %0d actual %0d",
                             $time, exp_d.index, digest_index);
                    errors++;
                end
                if (digest_last !== exp_d.last)
                begin
                    $display("%0t: digest_last expected %0b actual %0b",
                             $time, exp_d.last, digest_last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        wait (generation_done);
        @(posedge clk);
        while (pending_words.size() > 0 || in_valid || expected_digests.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_digests.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
